### rtl/alma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alma_pkg
// Shared constants and types for the ambient light moving average unit.
// ----------------------------------------------------------------------------
package alma_pkg;

  localparam int WINDOW      = 50;
  localparam int SAMPLE_BITS = 12;
  localparam int BRIGHT_BITS = 12;

  localparam int IDX_BITS = $clog2(WINDOW);
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW);

  // sum / WINDOW == (sum * RECIP) >> RECIP_SHIFT, exact for every sum below 2**SUM_BITS
  localparam int RECIP_SHIFT = SUM_BITS + IDX_BITS;
  localparam int RECIP_BITS  = RECIP_SHIFT - IDX_BITS + 2;
  localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [IDX_BITS-1:0]    LAST_IDX     = IDX_BITS'(WINDOW - 1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK  = '1;
  localparam logic [BRIGHT_BITS-1:0] INVALID_CODE = BRIGHT_BITS'(SAMPLE_MASK);

  // word leaving the ring stage
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   sub_old;  // window was full before this word
    logic                   full;     // window full after this word
  } alma_item_t;

endpackage

### rtl/ambient_light_moving_average_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_moving_average_unit
// Boxcar moving average over the last 50 light sensor samples.
//
//   channel   direction  content
//   s_axis    in         tdata[11:0] sample
//   m_axis    out        tdata[11:0] brightness, tuser[0] valid_res
//
// One word per cycle sustained while m_axis_tready stays high; each result passes
// the ring read, sum update and reciprocal multiply stages in that order.
// The ring is one memory read and written at the same slot in the accept
// cycle, so no forwarding is needed.
// rst clears index, fill flag, sum and all stage valids; ring contents are
// never used before written.
// Each stage holds under m_axis_tready low and empty stages still take words.
// ----------------------------------------------------------------------------
module ambient_light_moving_average_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] brightness
  output logic [0:0]  m_axis_tuser    // [0] valid_res
);
  import alma_pkg::*;

  alma_item_t             item;
  logic                   item_valid;
  logic                   item_ready;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic                   sum_valid;
  logic                   sum_ready;
  logic [SUM_BITS-1:0]    running_sum;
  logic                   sum_full;
  logic [BRIGHT_BITS-1:0] brightness;
  logic                   valid_res;

  alma_ring u_ring (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .old_sample (old_sample)
  );

  alma_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .old_sample  (old_sample),
    .sum_valid   (sum_valid),
    .sum_ready   (sum_ready),
    .running_sum (running_sum),
    .sum_full    (sum_full)
  );

  alma_div u_div (
    .clk         (clk),
    .rst         (rst),
    .sum_valid   (sum_valid),
    .sum_ready   (sum_ready),
    .running_sum (running_sum),
    .sum_full    (sum_full),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .brightness  (brightness),
    .valid_res   (valid_res)
  );

  assign m_axis_tdata = {{(16 - BRIGHT_BITS){1'b0}}, brightness};
  assign m_axis_tuser = valid_res;

endmodule

### rtl/alma_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alma_ring
// Sample ring memory with write index and fill flag; reads the oldest entry
// and stores the new sample at the same slot in the same cycle.
// ----------------------------------------------------------------------------
module alma_ring (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [alma_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            item_valid,
  input  logic                            item_ready,
  output alma_pkg::alma_item_t            item,
  output logic [alma_pkg::SAMPLE_BITS-1:0] old_sample
);
  import alma_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [WINDOW];
  logic [IDX_BITS-1:0]    write_index;
  logic                   window_full;
  logic                   accept;
  logic                   wrap;

  assign in_ready = !item_valid || item_ready;
  assign accept   = in_valid && in_ready;
  assign wrap     = (write_index == LAST_IDX);

  // read-before-write at the same slot: old_sample gets the evicted entry
  always_ff @(posedge clk) begin
    if (accept) begin
      old_sample       <= mem[write_index];
      mem[write_index] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.sample  <= in_sample;
      item.sub_old <= window_full;
      item.full    <= window_full || wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      window_full <= 1'b0;
      item_valid  <= 1'b0;
    end else begin
      if (accept) begin
        write_index <= wrap ? '0 : write_index + 1'b1;
        if (wrap) begin
          window_full <= 1'b1;
        end
      end
      if (in_ready) begin
        item_valid <= in_valid;
      end
    end
  end

endmodule

### rtl/alma_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alma_accum
// Running sum update: drops the evicted entry once the window is full and
// adds the new sample.
// ----------------------------------------------------------------------------
module alma_accum (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  alma_pkg::alma_item_t            item,
  input  logic [alma_pkg::SAMPLE_BITS-1:0] old_sample,
  output logic                            sum_valid,
  input  logic                            sum_ready,
  output logic [alma_pkg::SUM_BITS-1:0]   running_sum,
  output logic                            sum_full
);
  import alma_pkg::*;

  logic [SUM_BITS-1:0] running_sum_next;
  logic [SUM_BITS-1:0] sub_val;
  logic                fire;

  assign item_ready = !sum_valid || sum_ready;
  assign fire       = item_valid && item_ready;
  assign sub_val    = item.sub_old ? SUM_BITS'(old_sample) : '0;

  assign running_sum_next = running_sum - sub_val + SUM_BITS'(item.sample);

  // running_sum only moves when a word enters this stage, so it stays
  // matched to the word held in sum_valid until that word leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      sum_valid   <= 1'b0;
    end else begin
      if (fire) begin
        running_sum <= running_sum_next;
      end
      if (item_ready) begin
        sum_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sum_full <= item.full;
    end
  end

endmodule

### rtl/alma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alma_div
// Divide by the window length through a reciprocal multiply; output register.
// ----------------------------------------------------------------------------
module alma_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sum_valid,
  output logic                            sum_ready,
  input  logic [alma_pkg::SUM_BITS-1:0]   running_sum,
  input  logic                            sum_full,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [alma_pkg::BRIGHT_BITS-1:0] brightness,
  output logic                            valid_res
);
  import alma_pkg::*;

  logic [PROD_BITS-1:0]   prod;
  logic [SAMPLE_BITS-1:0] quotient;
  logic                   fire;

  assign sum_ready = !out_valid || out_ready;
  assign fire      = sum_valid && sum_ready;
  assign prod      = PROD_BITS'(running_sum) * PROD_BITS'(RECIP);
  assign quotient  = prod[RECIP_SHIFT +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (fire) begin
      brightness <= sum_full ? BRIGHT_BITS'(quotient) : INVALID_CODE;
      valid_res  <= sum_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sum_ready) begin
      out_valid <= sum_valid;
    end
  end

endmodule

### test/tb_ambient_light_moving_average_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ambient_light_moving_average_unit
// Self-checking bench for the 50-sample boxcar light average. A short table
// covers warm-up, the word that fills the window and the sample extremes; a
// long random stream follows. Every result word is compared with the typed
// result of its table row or with a local model of the ring, the running sum
// and the fill flag, with random stalls on both sides in the first two phases.
// ----------------------------------------------------------------------------
module tb_ambient_light_moving_average_unit;
  import alma_pkg::*;

  typedef struct packed {
    logic [BRIGHT_BITS-1:0] brightness;
    logic                   valid_res;
  } light_result_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [7:0]             reps;
    logic                   known;    // result typed in below
    logic [BRIGHT_BITS-1:0] brightness;
    logic                   valid_res;
  } stim_row_t;

  localparam int NUM_ROWS       = 10;
  localparam int RANDOM_PER_PHASE = 667;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;    // [11:0] sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [11:0] brightness
  logic [0:0]  m_axis_tuser;         // [0] valid_res

  ambient_light_moving_average_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  // model state
  logic [SAMPLE_BITS-1:0] light_ring [WINDOW];
  logic [SUM_BITS-1:0]    light_sum = '0;
  int unsigned            ring_slot = 0;
  bit                     ring_full = 1'b0;

  light_result_t results_due [$];
  int unsigned   mismatch_count = 0;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  int unsigned   light_level = 2048;

  stim_row_t stim_rows [NUM_ROWS];

  function automatic light_result_t average_next(input logic [SAMPLE_BITS-1:0] s);
    light_result_t r;
    if (ring_full) light_sum = light_sum - light_ring[ring_slot];
    light_sum = light_sum + s;
    light_ring[ring_slot] = s;
    ring_slot++;
    if (ring_slot >= WINDOW) begin
      ring_full = 1'b1;
      ring_slot = 0;
    end
    if (ring_full) begin
      r.brightness = BRIGHT_BITS'(light_sum / WINDOW);
      r.valid_res  = 1'b1;
    end else begin
      r.brightness = INVALID_CODE;
      r.valid_res  = 1'b0;
    end
    return r;
  endfunction

  // mostly uniform, some rail values, some noisy values around a light level that now and then jumps
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int unsigned pick;
    int          v;
    pick = $urandom_range(99);
    if (pick < 60) return SAMPLE_BITS'($urandom_range(4095));
    if (pick < 75) return $urandom_range(1) ? SAMPLE_MASK : '0;
    if ($urandom_range(19) == 0) light_level = $urandom_range(4095);
    v = int'(light_level) + int'($urandom_range(64)) - 32;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_BITS'(v);
  endfunction

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input bit known,
                             input light_result_t typed);
    light_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 16'(s);
    do @(posedge clk); while (!s_axis_tready);
    predicted = average_next(s);
    results_due.push_back(known ? typed : predicted);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected word brightness %0d valid_res %0b", $time,
                   m_axis_tdata[BRIGHT_BITS-1:0], m_axis_tuser[0]);
          mismatch_count++;
        end else begin
          if (m_axis_tdata[BRIGHT_BITS-1:0] !== results_due[0].brightness) begin
            $display("%0t: brightness expected %0d actual %0d", $time,
                     results_due[0].brightness, m_axis_tdata[BRIGHT_BITS-1:0]);
            mismatch_count++;
          end
          if (m_axis_tuser[0] !== results_due[0].valid_res) begin
            $display("%0t: valid_res expected %0b actual %0b", $time,
                     results_due[0].valid_res, m_axis_tuser[0]);
            mismatch_count++;
          end
          void'(results_due.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    light_result_t typed;
    for (int i = 0; i < WINDOW; i++) light_ring[i] = '0;
    stim_rows = '{
      // warm-up: invalid code until the window fills
      '{12'hFFF, 8'd49, 1'b1, INVALID_CODE, 1'b0},
      // the filling word already averages
      '{12'hFFF, 8'd1,  1'b1, 12'hFFF, 1'b1},
      '{12'h000, 8'd49, 1'b0, 12'h000, 1'b0},
      '{12'h000, 8'd1,  1'b1, 12'h000, 1'b1},
      '{12'h001, 8'd1,  1'b0, 12'h000, 1'b0},
      '{12'h800, 8'd1,  1'b0, 12'h000, 1'b0},
      '{12'hAAA, 8'd1,  1'b0, 12'h000, 1'b0},
      '{12'h555, 8'd1,  1'b0, 12'h000, 1'b0},
      '{12'h7FF, 8'd1,  1'b0, 12'h000, 1'b0},
      '{12'hFFE, 8'd1,  1'b0, 12'h000, 1'b0}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 11;
          rx_idle_pct = 79;
        end
        1: begin
          tx_idle_pct = 79;
          rx_idle_pct = 11;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (stim_rows[r]) begin
          typed.brightness = stim_rows[r].brightness;
          typed.valid_res  = stim_rows[r].valid_res;
          for (int k = 0; k < stim_rows[r].reps; k++)
            send_sample(stim_rows[r].sample, stim_rows[r].known, typed);
        end
      end
      typed = '0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_sample(pick_sample(), 1'b0, typed);
    end
    s_axis_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_ambient_light_moving_average_unit: clean");
    end else begin
      $display("tb_ambient_light_moving_average_unit: errors");
    end
    $finish;
  end

  // this time limit lies far beyond the run, even with the heaviest stalls
  initial begin
    #5_000_000;
    $display("tb_ambient_light_moving_average_unit: errors");
    $finish;
  end

endmodule

### ambient_light_moving_average_unit.f
rtl/alma_pkg.sv
rtl/alma_ring.sv
rtl/alma_accum.sv
rtl/alma_div.sv
rtl/ambient_light_moving_average_unit.sv
test/tb_ambient_light_moving_average_unit.sv
